>>> rtl/obb_overlap_test_core_defines.svh
// Assertion macros for the oriented-box overlap test core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef OBB_OVERLAP_TEST_CORE_DEFINES_SVH
`define OBB_OVERLAP_TEST_CORE_DEFINES_SVH

`ifndef SYNTH
`define OBB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`else
`define OBB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`ifndef SYNTH
`define OBB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define OBB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/obb_pkg.sv
// Shared widths, types and helpers for the oriented-box overlap test core.
// No dependencies.
`default_nettype none
package obb_pkg;
    localparam int DW = 35;   // center difference projected on an axis, Q.18
    localparam int CW = 34;   // axis dot product, Q2.28
    localparam int PW = 51;   // extent times |dot|, Q.32
    localparam int FW = 54;   // face test operands, Q.32
    localparam int XW = 69;   // center projection times dot, Q.46
    localparam int GW = 71;   // cross test operands, Q.46
    localparam int CUTW = 29;
    localparam logic [CUTW-1:0] CUTOFF_RESET = 29'd268435187;

    typedef struct packed {
        logic en;
        logic vld;
    } t_ctl;

    function automatic logic signed [15:0] comp16(input logic [47:0] w, input int k);
        return $signed(w[16*k +: 16]);
    endfunction

    function automatic int nxt3(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    function automatic int prv3(input int i);
        return (i == 0) ? 2 : i - 1;
    endfunction
endpackage
`default_nettype wire

>>> rtl/obb_dot.sv
// First stage: axis dot matrix and center difference projections.
// Depends on obb_pkg.
`default_nettype none
module obb_dot import obb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic [47:0]       i_fld [10],
    output logic                   o_vld,
    output logic signed [CW-1:0]   o_c [3][3],
    output logic signed [DW-1:0]   o_d [3],
    output logic signed [DW-1:0]   o_db [3],
    output logic signed [15:0]     o_ea [3],
    output logic signed [15:0]     o_eb [3]
);
    logic signed [16:0]   diff [3];
    logic signed [CW-1:0] n_c [3][3], r_c [3][3];
    logic signed [DW-1:0] n_d [3], r_d [3], n_db [3], r_db [3];
    logic signed [15:0]   n_ea [3], r_ea [3], n_eb [3], r_eb [3];
    logic                 r_vld;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = 17'(comp16(i_fld[0], k)) - 17'(comp16(i_fld[5], k));
            n_ea[k] = comp16(i_fld[4], k);
            n_eb[k] = comp16(i_fld[9], k);
        end
        for (int i = 0; i < 3; i++) begin
            n_d[i]  = '0;
            n_db[i] = '0;
            for (int k = 0; k < 3; k++) begin
                n_d[i]  = n_d[i] + DW'(diff[k]) * DW'(comp16(i_fld[1+i], k));
                n_db[i] = n_db[i] + DW'(diff[k]) * DW'(comp16(i_fld[6+i], k));
            end
            for (int j = 0; j < 3; j++) begin
                n_c[i][j] = '0;
                for (int k = 0; k < 3; k++) begin
                    n_c[i][j] = n_c[i][j]
                        + CW'(comp16(i_fld[1+i], k)) * CW'(comp16(i_fld[6+j], k));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_c  <= n_c;
            r_d  <= n_d;
            r_db <= n_db;
            r_ea <= n_ea;
            r_eb <= n_eb;
        end
    end

    assign o_vld = r_vld;
    assign o_c   = r_c;
    assign o_d   = r_d;
    assign o_db  = r_db;
    assign o_ea  = r_ea;
    assign o_eb  = r_eb;
endmodule
`default_nettype wire

>>> rtl/obb_prod.sv
// Second stage: absolute dots, parallel flag and all radius and cross products.
// Depends on obb_pkg.
`default_nettype none
module obb_prod import obb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic [CUTW-1:0]   i_cutoff,
    input  wire logic signed [CW-1:0] i_c [3][3],
    input  wire logic signed [DW-1:0] i_d [3],
    input  wire logic signed [DW-1:0] i_db [3],
    input  wire logic signed [15:0] i_ea [3],
    input  wire logic signed [15:0] i_eb [3],
    output logic                   o_vld,
    output logic                   o_par,
    output logic [DW-1:0]          o_ad [3],
    output logic [DW-1:0]          o_adb [3],
    output logic signed [15:0]     o_ea [3],
    output logic signed [15:0]     o_eb [3],
    output logic signed [PW-1:0]   o_pfa [3][3],
    output logic signed [PW-1:0]   o_pfb [3][3],
    output logic signed [PW-1:0]   o_ra0 [3][3],
    output logic signed [PW-1:0]   o_ra1 [3][3],
    output logic signed [PW-1:0]   o_rb0 [3][3],
    output logic signed [PW-1:0]   o_rb1 [3][3],
    output logic signed [XW-1:0]   o_x1 [3][3],
    output logic signed [XW-1:0]   o_x2 [3][3]
);
    logic [CW-1:0]        ac [3][3];
    logic                 n_par, r_par, r_vld;
    logic [DW-1:0]        n_ad [3], r_ad [3], n_adb [3], r_adb [3];
    logic signed [15:0]   r_ea [3], r_eb [3];
    logic signed [PW-1:0] n_pfa [3][3], r_pfa [3][3], n_pfb [3][3], r_pfb [3][3];
    logic signed [PW-1:0] n_ra0 [3][3], r_ra0 [3][3], n_ra1 [3][3], r_ra1 [3][3];
    logic signed [PW-1:0] n_rb0 [3][3], r_rb0 [3][3], n_rb1 [3][3], r_rb1 [3][3];
    logic signed [XW-1:0] n_x1 [3][3], r_x1 [3][3], n_x2 [3][3], r_x2 [3][3];

    always_comb begin
        n_par = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_ad[i]  = i_d[i][DW-1] ? DW'(-i_d[i]) : DW'(i_d[i]);
            n_adb[i] = i_db[i][DW-1] ? DW'(-i_db[i]) : DW'(i_db[i]);
            for (int j = 0; j < 3; j++) begin
                ac[i][j] = i_c[i][j][CW-1] ? CW'(-i_c[i][j]) : CW'(i_c[i][j]);
                if (ac[i][j] > CW'(i_cutoff)) begin
                    n_par = 1'b1;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pfa[i][j] = PW'(i_eb[j]) * PW'($signed(ac[i][j]));
                n_pfb[i][j] = PW'(i_ea[i]) * PW'($signed(ac[i][j]));
                n_ra0[i][j] = PW'(i_ea[nxt3(i)]) * PW'($signed(ac[prv3(i)][j]));
                n_ra1[i][j] = PW'(i_ea[prv3(i)]) * PW'($signed(ac[nxt3(i)][j]));
                n_rb0[i][j] = PW'(i_eb[nxt3(j)]) * PW'($signed(ac[i][prv3(j)]));
                n_rb1[i][j] = PW'(i_eb[prv3(j)]) * PW'($signed(ac[i][nxt3(j)]));
                n_x1[i][j]  = XW'(i_d[prv3(i)]) * XW'(i_c[nxt3(i)][j]);
                n_x2[i][j]  = XW'(i_d[nxt3(i)]) * XW'(i_c[prv3(i)][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_par <= n_par;
            r_ad  <= n_ad;
            r_adb <= n_adb;
            r_ea  <= i_ea;
            r_eb  <= i_eb;
            r_pfa <= n_pfa;
            r_pfb <= n_pfb;
            r_ra0 <= n_ra0;
            r_ra1 <= n_ra1;
            r_rb0 <= n_rb0;
            r_rb1 <= n_rb1;
            r_x1  <= n_x1;
            r_x2  <= n_x2;
        end
    end

    assign o_vld = r_vld;
    assign o_par = r_par;
    assign o_ad  = r_ad;
    assign o_adb = r_adb;
    assign o_ea  = r_ea;
    assign o_eb  = r_eb;
    assign o_pfa = r_pfa;
    assign o_pfb = r_pfb;
    assign o_ra0 = r_ra0;
    assign o_ra1 = r_ra1;
    assign o_rb0 = r_rb0;
    assign o_rb1 = r_rb1;
    assign o_x1  = r_x1;
    assign o_x2  = r_x2;
endmodule
`default_nettype wire

>>> rtl/obb_sum.sv
// Third stage: projection magnitudes and radii for all fifteen axes.
// Depends on obb_pkg.
`default_nettype none
module obb_sum import obb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic              i_par,
    input  wire logic [DW-1:0]     i_ad [3],
    input  wire logic [DW-1:0]     i_adb [3],
    input  wire logic signed [15:0] i_ea [3],
    input  wire logic signed [15:0] i_eb [3],
    input  wire logic signed [PW-1:0] i_pfa [3][3],
    input  wire logic signed [PW-1:0] i_pfb [3][3],
    input  wire logic signed [PW-1:0] i_ra0 [3][3],
    input  wire logic signed [PW-1:0] i_ra1 [3][3],
    input  wire logic signed [PW-1:0] i_rb0 [3][3],
    input  wire logic signed [PW-1:0] i_rb1 [3][3],
    input  wire logic signed [XW-1:0] i_x1 [3][3],
    input  wire logic signed [XW-1:0] i_x2 [3][3],
    output logic                   o_vld,
    output logic                   o_par,
    output logic signed [FW-1:0]   o_fl [6],
    output logic signed [FW-1:0]   o_fr [6],
    output logic signed [GW-1:0]   o_xl [3][3],
    output logic signed [GW-1:0]   o_xr [3][3]
);
    logic signed [XW:0]   xd [3][3];
    logic signed [FW-1:0] n_fl [6], r_fl [6], n_fr [6], r_fr [6];
    logic signed [GW-1:0] n_xl [3][3], r_xl [3][3], n_xr [3][3], r_xr [3][3];
    logic                 r_vld, r_par;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fl[i]   = $signed(FW'(i_ad[i])) <<< 14;
            n_fl[3+i] = $signed(FW'(i_adb[i])) <<< 14;
            n_fr[i]   = (FW'(i_ea[i]) <<< 28) + FW'(i_pfa[i][0])
                        + FW'(i_pfa[i][1]) + FW'(i_pfa[i][2]);
            n_fr[3+i] = (FW'(i_eb[i]) <<< 28) + FW'(i_pfb[0][i])
                        + FW'(i_pfb[1][i]) + FW'(i_pfb[2][i]);
            for (int j = 0; j < 3; j++) begin
                xd[i][j]   = (XW+1)'(i_x1[i][j]) - (XW+1)'(i_x2[i][j]);
                n_xl[i][j] = xd[i][j][XW] ? -GW'(xd[i][j]) : GW'(xd[i][j]);
                n_xr[i][j] = (GW'(i_ra0[i][j]) + GW'(i_ra1[i][j])
                              + GW'(i_rb0[i][j]) + GW'(i_rb1[i][j])) <<< 14;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_par <= i_par;
            r_fl  <= n_fl;
            r_fr  <= n_fr;
            r_xl  <= n_xl;
            r_xr  <= n_xr;
        end
    end

    assign o_vld = r_vld;
    assign o_par = r_par;
    assign o_fl  = r_fl;
    assign o_fr  = r_fr;
    assign o_xl  = r_xl;
    assign o_xr  = r_xr;
endmodule
`default_nettype wire

>>> rtl/obb_test.sv
// Fourth stage: axis compares and the registered overlap word.
// Depends on obb_pkg.
`default_nettype none
module obb_test import obb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctl              i_ctl,
    input  wire logic              i_par,
    input  wire logic signed [FW-1:0] i_fl [6],
    input  wire logic signed [FW-1:0] i_fr [6],
    input  wire logic signed [GW-1:0] i_xl [3][3],
    input  wire logic signed [GW-1:0] i_xr [3][3],
    output logic                   o_vld,
    output logic                   o_overlap
);
    logic sep_face, sep_x, n_overlap, r_overlap, r_vld;

    always_comb begin
        sep_face = 1'b0;
        sep_x    = 1'b0;
        for (int k = 0; k < 6; k++) begin
            if (i_fl[k] > i_fr[k]) begin
                sep_face = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_xl[i][j] > i_xr[i][j]) begin
                    sep_x = 1'b1;
                end
            end
        end
        // skip cross axes for a near-parallel pair
        n_overlap = !(sep_face || (!i_par && sep_x));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_overlap <= n_overlap;
        end
    end

    assign o_vld     = r_vld;
    assign o_overlap = r_overlap;
endmodule
`default_nettype wire

>>> rtl/obb_overlap_test_core.sv
// Top level of the oriented-box overlap test: stage chain and cutoff register.
// Depends on obb_pkg, obb_dot, obb_prod, obb_sum, obb_test and the defines header.
//
// One box pair enters per cycle while o_stall is low, and its overlap word leaves through
// the four register stages (dot matrix, products, sums, compares); the last stage is the
// output register. A stall on the output freezes only the stages that are full, so bubbles
// close up. The parallel cutoff register (Q1.28) is to be written by the user only while
// the core is idle; the block itself does not enforce this. It takes effect on the next word accepted.
`default_nettype none
`include "obb_overlap_test_core_defines.svh"
module obb_overlap_test_core import obb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [47:0]       i_center_a,
    input  wire logic [47:0]       i_axis_ax,
    input  wire logic [47:0]       i_axis_ay,
    input  wire logic [47:0]       i_axis_az,
    input  wire logic [47:0]       i_extent_a,
    input  wire logic [47:0]       i_center_b,
    input  wire logic [47:0]       i_axis_bx,
    input  wire logic [47:0]       i_axis_by,
    input  wire logic [47:0]       i_axis_bz,
    input  wire logic [47:0]       i_extent_b,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_overlap,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CUTW-1:0]   i_cfg_data
);
    logic [47:0]          fld [10];
    logic [CUTW-1:0]      r_cutoff;
    logic                 v1, v2, v3, v4, rdy1, rdy2, rdy3, rdy4;
    t_ctl                 ctl1, ctl2, ctl3, ctl4;
    logic signed [CW-1:0] c [3][3];
    logic signed [DW-1:0] d [3], db [3];
    logic signed [15:0]   ea1 [3], eb1 [3], ea2 [3], eb2 [3];
    logic                 par2, par3;
    logic [DW-1:0]        ad [3], adb [3];
    logic signed [PW-1:0] pfa [3][3], pfb [3][3];
    logic signed [PW-1:0] ra0 [3][3], ra1 [3][3], rb0 [3][3], rb1 [3][3];
    logic signed [XW-1:0] x1 [3][3], x2 [3][3];
    logic signed [FW-1:0] fl [6], fr [6];
    logic signed [GW-1:0] xl [3][3], xr [3][3];

    assign fld = '{i_center_a, i_axis_ax, i_axis_ay, i_axis_az, i_extent_a,
                   i_center_b, i_axis_bx, i_axis_by, i_axis_bz, i_extent_b};

    assign rdy4    = !v4 || !i_stall;
    assign rdy3    = !v3 || rdy4;
    assign rdy2    = !v2 || rdy3;
    assign rdy1    = !v1 || rdy2;
    assign o_stall = !rdy1;

    assign ctl1 = '{en: rdy1, vld: i_valid};
    assign ctl2 = '{en: rdy2, vld: v1};
    assign ctl3 = '{en: rdy3, vld: v2};
    assign ctl4 = '{en: rdy4, vld: v3};

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (i_cfg_valid) begin
            r_cutoff <= i_cfg_data;
        end
    end

    obb_dot u_dot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl1), .i_fld(fld),
        .o_vld(v1), .o_c(c), .o_d(d), .o_db(db), .o_ea(ea1), .o_eb(eb1)
    );

    obb_prod u_prod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl2), .i_cutoff(r_cutoff),
        .i_c(c), .i_d(d), .i_db(db), .i_ea(ea1), .i_eb(eb1),
        .o_vld(v2), .o_par(par2), .o_ad(ad), .o_adb(adb), .o_ea(ea2), .o_eb(eb2),
        .o_pfa(pfa), .o_pfb(pfb), .o_ra0(ra0), .o_ra1(ra1), .o_rb0(rb0), .o_rb1(rb1),
        .o_x1(x1), .o_x2(x2)
    );

    obb_sum u_sum (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl3), .i_par(par2),
        .i_ad(ad), .i_adb(adb), .i_ea(ea2), .i_eb(eb2),
        .i_pfa(pfa), .i_pfb(pfb), .i_ra0(ra0), .i_ra1(ra1), .i_rb0(rb0), .i_rb1(rb1),
        .i_x1(x1), .i_x2(x2),
        .o_vld(v3), .o_par(par3), .o_fl(fl), .o_fr(fr), .o_xl(xl), .o_xr(xr)
    );

    obb_test u_test (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl4), .i_par(par3),
        .i_fl(fl), .i_fr(fr), .i_xl(xl), .i_xr(xr),
        .o_vld(v4), .o_overlap(o_overlap)
    );

    assign o_valid = v4;

    `OBB_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, v1 && v2 && v3 && v4 && i_stall)
    `OBB_ASSERT_NXT(a_take_first, i_clk, i_rst_n, i_valid && !o_stall, v1)
    `OBB_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n, i_cfg_valid, r_cutoff == $past(i_cfg_data))
endmodule
`default_nettype wire
